// ===== design/rgbconv_pkg.sv =====
package rgbconv_pkg;

    localparam int KSIZE     = 5;
    localparam int TAPS      = KSIZE * KSIZE;
    localparam int COEF_BITS = 12;
    localparam int PIX_BITS  = 24;
    localparam int CFG_W     = 60;

    // register indexes of the config port
    localparam logic [2:0] CFG_IMG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_IMG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_MASK_ROW0  = 3'd2;
    localparam logic [2:0] CFG_MASK_ROW4  = 3'd6;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       run_last;
    } t_out_item;

    // 5x5 window of packed pixels: [row][col], row 0 oldest, col 0 leftmost
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_BITS-1:0] t_win;
    typedef logic [TAPS-1:0][7:0]                      t_tap_pix;
    typedef logic [TAPS-1:0][COEF_BITS-1:0]            t_tap_coef;

    // window moved up by s rows and left by t columns, zero fill
    function automatic t_win shift_win(t_win w, logic [1:0] s, logic [1:0] t);
        t_win v;
        t_win u;
        v = '0;
        u = '0;
        for (int k = 0; k < KSIZE; k++) begin
            case (s)
                2'd0: v[k] = w[k];
                2'd1: if (k + 1 < KSIZE) v[k] = w[(k + 1) % KSIZE];
                2'd2: if (k + 2 < KSIZE) v[k] = w[(k + 2) % KSIZE];
                default: v[k] = '0;
            endcase
        end
        for (int k = 0; k < KSIZE; k++) begin
            for (int m = 0; m < KSIZE; m++) begin
                case (t)
                    2'd0: u[k][m] = v[k][m];
                    2'd1: if (m + 1 < KSIZE) u[k][m] = v[k][(m + 1) % KSIZE];
                    2'd2: if (m + 2 < KSIZE) u[k][m] = v[k][(m + 2) % KSIZE];
                    default: u[k][m] = '0;
                endcase
            end
        end
        return u;
    endfunction

endpackage

// ===== design/rgbconv_ram.sv =====
module rgbconv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// ===== design/rgbconv_lane.sv =====
module rgbconv_lane
    import rgbconv_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_ce,
    input  t_tap_pix  i_pix,
    input  t_tap_coef i_coef,
    output logic [7:0] o_val
);

    localparam int PROD_W = COEF_BITS + 9;
    localparam int RSUM_W = PROD_W + 3;
    localparam int ACC_W  = RSUM_W + 3;

    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [RSUM_W-1:0] r_rsum [KSIZE];
    logic signed [RSUM_W-1:0] n_rsum [KSIZE];
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  n_q;
    logic [7:0]               n_val;
    logic [7:0]               r_val;

    // stage 1: 25 products, pixel taken as unsigned
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int n = 0; n < TAPS; n++) begin
                r_prod[n] <= PROD_W'($signed({1'b0, i_pix[n]}) * $signed(i_coef[n]));
            end
        end
    end

    // stage 2: per mask row sums
    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            n_rsum[k] = '0;
            for (int m = 0; m < KSIZE; m++) begin
                n_rsum[k] = n_rsum[k] + RSUM_W'(r_prod[k * KSIZE + m]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rsum <= n_rsum;
        end
    end

    // stage 3: total, floor shift, saturate
    always_comb begin
        n_acc = '0;
        for (int k = 0; k < KSIZE; k++) begin
            n_acc = n_acc + ACC_W'(r_rsum[k]);
        end
        n_q = n_acc >>> FRAC_BITS;
        if (n_acc < 0) begin
            n_val = 8'd0;
        end else if (n_q > ACC_W'(255)) begin
            n_val = 8'd255;
        end else begin
            n_val = n_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

// ===== design/rgb_conv5x5_zero_pad_clamp_top.sv =====
// Path: a result passes stage A, the window sequencer, the lane stages and the
// output register. Throughput: one pixel per cycle while the output is not
// stalled; at row end and at frame end the pixel holds the input, since the
// window sequencer issues one result per cycle to the three color lanes.
// Reset: control, counters and config registers clear; the line store does not.
module rgb_conv5x5_zero_pad_clamp_top
    import rgbconv_pkg::*;
#(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = COL_W + 1;
    localparam int HD_W  = ROW_W + 1;
    localparam int LAT   = 3;   // lane pipeline depth

    // ---------------- configuration registers ----------------
    logic [10:0]      r_width;
    logic [10:0]      r_height;
    logic [CFG_W-1:0] r_mask [KSIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd64;
            r_height <= 11'd64;
            for (int k = 0; k < KSIZE; k++) begin
                r_mask[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_IMG_WIDTH) begin
                r_width <= i_cfg_wdata[10:0];
            end else if (i_cfg_index == CFG_IMG_HEIGHT) begin
                r_height <= i_cfg_wdata[10:0];
            end else if (i_cfg_index >= CFG_MASK_ROW0 && i_cfg_index <= CFG_MASK_ROW4) begin
                r_mask[3'(i_cfg_index - CFG_MASK_ROW0)] <= i_cfg_wdata;
            end
        end
    end

    // effective size, saturated to 1..MAX
    logic [WD_W-1:0] w_eff;
    logic [HD_W-1:0] h_eff;

    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = WD_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(r_width);
        end
        if (r_height == 11'd0) begin
            h_eff = HD_W'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HD_W'(MAX_HEIGHT);
        end else begin
            h_eff = HD_W'(r_height);
        end
    end

    // coefficients, tap n = row*5 + col
    t_tap_coef coefs;
    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            for (int m = 0; m < KSIZE; m++) begin
                coefs[k * KSIZE + m] = r_mask[k][m * COEF_BITS +: COEF_BITS];
            end
        end
    end

    // ---------------- handshake control ----------------
    // whole pipeline moves when the output register can take a beat
    logic adv;
    logic accept;
    logic seq_last;
    logic seq_free_next;
    logic a_move;

    logic r_out_valid;
    logic r_a_valid;
    logic r_seq_valid;

    assign adv           = !r_out_valid || i_out_ready;
    assign seq_free_next = !r_seq_valid || (adv && seq_last);
    assign a_move        = adv && r_a_valid && seq_free_next;
    assign o_in_ready    = adv && (!r_a_valid || seq_free_next);
    assign accept        = i_in_valid && o_in_ready;

    // ---------------- position counters ----------------
    logic [ROW_W-1:0] r_cur_row;
    logic [COL_W-1:0] r_cur_col;
    logic [2:0]       r_bank;      // cur_row mod 5

    logic [ROW_W-1:0] ir;
    logic [COL_W-1:0] ic;
    logic [2:0]       bank;
    logic             lrow;
    logic             lcol;

    always_comb begin
        // out-of-range position after a size change starts a new frame
        if ({1'b0, r_cur_row} >= h_eff || {1'b0, r_cur_col} >= w_eff) begin
            ir   = '0;
            ic   = '0;
            bank = 3'd0;
        end else begin
            ir   = r_cur_row;
            ic   = r_cur_col;
            bank = r_bank;
        end
        lrow = (HD_W'(ir) + HD_W'(1)) == h_eff;
        lcol = (WD_W'(ic) + WD_W'(1)) == w_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_bank    <= 3'd0;
        end else if (accept) begin
            if (lcol) begin
                r_cur_col <= '0;
                if (lrow) begin
                    r_cur_row <= '0;
                    r_bank    <= 3'd0;
                end else begin
                    r_cur_row <= ir + ROW_W'(1);
                    r_bank    <= (bank == 3'd4) ? 3'd0 : bank + 3'd1;
                end
            end else begin
                r_cur_row <= ir;
                r_cur_col <= ic + COL_W'(1);
                r_bank    <= bank;
            end
        end
    end

    // ---------------- line store: one bank per row mod 5 ----------------
    logic [PIX_BITS-1:0] pix_in;
    logic [PIX_BITS-1:0] bank_q [KSIZE];

    assign pix_in = {i_in_data.in_blue, i_in_data.in_green, i_in_data.in_red};

    for (genvar g = 0; g < KSIZE; g++) begin : g_bank
        rgbconv_ram #(
            .WIDTH (PIX_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (accept && (bank == 3'(g))),
            .i_wr_addr (ic),
            .i_wr_data (pix_in),
            .i_rd_en   (accept),
            .i_rd_addr (ic),
            .o_rd_data (bank_q[g])
        );
    end

    // ---------------- stage A: pixel waits for its column read ----------------
    logic [PIX_BITS-1:0] r_a_pix;
    logic [ROW_W-1:0]    r_a_row;
    logic [COL_W-1:0]    r_a_col;
    logic [2:0]          r_a_bank;
    logic                r_a_lrow;
    logic                r_a_lcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix  <= pix_in;
            r_a_row  <= ir;
            r_a_col  <= ic;
            r_a_bank <= bank;
            r_a_lrow <= lrow;
            r_a_lcol <= lcol;
        end
    end

    // new window column: entry k is row ir-4+k, bottom entry is the new pixel
    logic [KSIZE-1:0][PIX_BITS-1:0] new_col;
    logic [3:0]                     bidx [KSIZE-1];

    always_comb begin
        for (int k = 0; k < KSIZE - 1; k++) begin
            bidx[k] = 4'(r_a_bank) + 4'(k + 1);
            if (bidx[k] >= 4'(KSIZE)) begin
                bidx[k] = bidx[k] - 4'(KSIZE);
            end
            new_col[k] = bank_q[3'(bidx[k])];
        end
        new_col[KSIZE-1] = r_a_pix;
    end

    // shifted window, then masked for rows and columns above/left of the image
    t_win r_win;
    t_win n_win;
    t_win n_base;

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            for (int m = 0; m < KSIZE - 1; m++) begin
                n_win[k][m] = r_win[k][m + 1];
            end
            n_win[k][KSIZE-1] = new_col[k];
        end
        for (int k = 0; k < KSIZE; k++) begin
            for (int m = 0; m < KSIZE; m++) begin
                if ((int'(r_a_row) + k) >= KSIZE - 1 && (int'(r_a_col) + m) >= KSIZE - 1) begin
                    n_base[k][m] = n_win[k][m];
                end else begin
                    n_base[k][m] = '0;
                end
            end
        end
    end

    // ---------------- window sequencer ----------------
    // result (ir-2+s, ic-2+t) for s in s0..s1, t in t0..t1
    t_win             r_base;
    logic [ROW_W-1:0] r_ir;
    logic [COL_W-1:0] r_ic;
    logic [1:0]       r_s;
    logic [1:0]       r_t;
    logic [1:0]       r_t0;
    logic [1:0]       r_s1;
    logic [1:0]       r_t1;

    logic [1:0] s0;
    logic [1:0] t0;
    logic       has_rows;
    logic       has_cols;

    always_comb begin
        if (r_a_row == ROW_W'(0)) begin
            s0 = r_a_lrow ? 2'd2 : 2'd0;
        end else if (r_a_row == ROW_W'(1)) begin
            s0 = r_a_lrow ? 2'd1 : 2'd0;
        end else begin
            s0 = 2'd0;
        end
        if (r_a_col == COL_W'(0)) begin
            t0 = r_a_lcol ? 2'd2 : 2'd0;
        end else if (r_a_col == COL_W'(1)) begin
            t0 = r_a_lcol ? 2'd1 : 2'd0;
        end else begin
            t0 = 2'd0;
        end
        has_rows = r_a_lrow || (r_a_row >= ROW_W'(2));
        has_cols = r_a_lcol || (r_a_col >= COL_W'(2));
    end

    assign seq_last = (r_s == r_s1) && (r_t == r_t1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
        end else if (a_move) begin
            r_seq_valid <= has_rows && has_cols;
        end else if (adv && seq_last) begin
            r_seq_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_win  <= n_win;
            r_base <= n_base;
            r_ir   <= r_a_row;
            r_ic   <= r_a_col;
            r_s    <= s0;
            r_t    <= t0;
            r_t0   <= t0;
            r_s1   <= r_a_lrow ? 2'd2 : 2'd0;
            r_t1   <= r_a_lcol ? 2'd2 : 2'd0;
        end else if (adv && r_seq_valid && !seq_last) begin
            if (r_t == r_t1) begin
                r_t <= r_t0;
                r_s <= r_s + 2'd1;
            end else begin
                r_t <= r_t + 2'd1;
            end
        end
    end

    // issued window and coordinates
    t_win             iss_win;
    logic [ROW_W-1:0] iss_row;
    logic [COL_W-1:0] iss_col;
    t_tap_pix         lane_pix [3];

    assign iss_win = shift_win(r_base, r_s, r_t);
    assign iss_row = r_ir + ROW_W'(r_s) - ROW_W'(2);
    assign iss_col = r_ic + COL_W'(r_t) - COL_W'(2);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < KSIZE; k++) begin
                for (int m = 0; m < KSIZE; m++) begin
                    lane_pix[ch][k * KSIZE + m] = iss_win[k][m][ch * 8 +: 8];
                end
            end
        end
    end

    // ---------------- color lanes ----------------
    logic [7:0] lane_val [3];

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rgbconv_lane #(
            .FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ce   (adv),
            .i_pix  (lane_pix[ch]),
            .i_coef (coefs),
            .o_val  (lane_val[ch])
        );
    end

    // beat info travels beside the lanes
    logic       r_p_valid [LAT];
    logic [9:0] r_p_row   [LAT];
    logic [9:0] r_p_col   [LAT];
    logic       r_p_last  [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < LAT; p++) begin
                r_p_valid[p] <= 1'b0;
            end
        end else if (adv) begin
            r_p_valid[0] <= r_seq_valid;
            for (int p = 1; p < LAT; p++) begin
                r_p_valid[p] <= r_p_valid[p - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_row[0]  <= 10'(iss_row);
            r_p_col[0]  <= 10'(iss_col);
            r_p_last[0] <= seq_last;
            for (int p = 1; p < LAT; p++) begin
                r_p_row[p]  <= r_p_row[p - 1];
                r_p_col[p]  <= r_p_col[p - 1];
                r_p_last[p] <= r_p_last[p - 1];
            end
        end
    end

    // ---------------- merge into output register ----------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p_valid[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_row   <= r_p_row[LAT-1];
            r_out.out_col   <= r_p_col[LAT-1];
            r_out.out_red   <= lane_val[0];
            r_out.out_green <= lane_val[1];
            r_out.out_blue  <= lane_val[2];
            r_out.run_last  <= r_p_last[LAT-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/rgb_conv5x5_zero_pad_clamp_top_tb.sv =====
module rgb_conv5x5_zero_pad_clamp_top_tb;
    import rgbconv_pkg::*;

    localparam int MAX_W     = 1024;
    localparam int MAX_H     = 1024;
    localparam int FRAC_BITS = 10;

    // Predicts the filtered pixels from accepted input beats and holds
    // them in arrival order until the block hands them out.
    class conv_scoreboard;
        logic [10:0]   width_reg;
        logic [10:0]   height_reg;
        logic [59:0]   mask_reg [KSIZE];
        logic [23:0]   lines [KSIZE*MAX_W];
        int            row_pos;
        int            col_pos;
        t_out_item     expected_q [$];
        int            errors;

        function new();
            width_reg  = 11'd64;
            height_reg = 11'd64;
            foreach (mask_reg[i]) mask_reg[i] = '0;
            foreach (lines[i]) lines[i] = '0;
            row_pos = 0;
            col_pos = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_IMG_WIDTH) width_reg = val[10:0];
            else if (idx == CFG_IMG_HEIGHT) height_reg = val[10:0];
            else if (idx >= CFG_MASK_ROW0 && idx <= CFG_MASK_ROW4)
                mask_reg[idx - CFG_MASK_ROW0] = val;
        endfunction

        function int eff_w();
            return (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
        endfunction

        function int eff_h();
            return (height_reg == 0) ? 1 : (height_reg > MAX_H) ? MAX_H : int'(height_reg);
        endfunction

        function logic [7:0] clamp_acc(int acc);
            int q;
            if (acc < 0) return 8'd0;
            q = acc >>> FRAC_BITS;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function t_out_item filter_px(int r, int c, int w, int h);
            t_out_item o;
            int acc [3];
            int y, x;
            logic signed [11:0] k;
            logic [23:0] px;
            acc = '{0, 0, 0};
            for (int i = 0; i < KSIZE; i++) begin
                y = r + i - 2;
                if (y < 0 || y >= h) continue;
                for (int j = 0; j < KSIZE; j++) begin
                    x = c + j - 2;
                    if (x < 0 || x >= w) continue;
                    px = lines[(y % KSIZE) * MAX_W + x];
                    k  = mask_reg[i][COEF_BITS*j +: COEF_BITS];
                    for (int ch = 0; ch < 3; ch++)
                        acc[ch] += int'(px[8*ch +: 8]) * int'(k);
                end
            end
            o.out_row   = r[9:0];
            o.out_col   = c[9:0];
            o.out_red   = clamp_acc(acc[0]);
            o.out_green = clamp_acc(acc[1]);
            o.out_blue  = clamp_acc(acc[2]);
            o.run_last  = 1'b0;
            return o;
        endfunction

        function void note_pixel(t_in_item px);
            int w, h, r0, r1, c0, c1;
            w = eff_w();
            h = eff_h();
            // a shrink in mid-frame restarts the frame
            if (row_pos >= h || col_pos >= w) begin
                row_pos = 0;
                col_pos = 0;
            end
            lines[(row_pos % KSIZE) * MAX_W + col_pos] =
                {px.in_blue, px.in_green, px.in_red};
            if (row_pos == h - 1) begin
                r0 = (row_pos >= 2) ? row_pos - 2 : 0;
                r1 = row_pos;
            end else begin
                r0 = row_pos - 2;
                r1 = row_pos - 2;
            end
            if (col_pos == w - 1) begin
                c0 = (col_pos >= 2) ? col_pos - 2 : 0;
                c1 = col_pos;
            end else begin
                c0 = col_pos - 2;
                c1 = col_pos - 2;
            end
            if (r0 >= 0 && c0 >= 0) begin
                for (int r = r0; r <= r1; r++)
                    for (int c = c0; c <= c1; c++)
                        expected_q.insert(expected_q.size(), filter_px(r, c, w, h));
                expected_q[$].run_last = 1'b1;
            end
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_px;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: %p", got);
                return;
            end
            exp_px = expected_q.pop_front();
            if (got !== exp_px) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", exp_px, got);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_wr_en = 1'b0;
    logic [2:0]       i_cfg_index = CFG_IMG_WIDTH;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    conv_scoreboard sb = new();

    // quiet: no idling on either side; hold_left: receiver back-pressure
    // stretch, counted down by the receiver itself
    bit quiet = 1'b0;
    int hold_left = 0;
    int sent = 0;

    rgb_conv5x5_zero_pad_clamp_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mode 0: any 12-bit value; mode 1: modest weights so results spread
    function automatic logic [59:0] rand_mask_row(int mode);
        logic [59:0] v;
        int k;
        for (int j = 0; j < KSIZE; j++) begin
            k = (mode == 0) ? int'($urandom_range(0, 4095)) : $urandom_range(0, 600) - 300;
            v[COEF_BITS*j +: COEF_BITS] = k[11:0];
        end
        return v;
    endfunction

    function automatic t_in_item rand_pixel();
        t_in_item px;
        px = t_in_item'($urandom);
        return px;
    endfunction

    // walks the byte extremes and alternating bit patterns over the channels
    function automatic t_in_item corner_pixel(int n);
        logic [7:0] pat [6];
        pat = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        return '{in_red: pat[n % 6], in_green: pat[(n + 1) % 6], in_blue: pat[(n + 3) % 6]};
    endfunction

    // config beats run back to back, en drops only after the last one
    task automatic cfg_write(logic [2:0] idx, logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_close();
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_masks(int mode);
        for (int i = 0; i < KSIZE; i++)
            cfg_write(CFG_MASK_ROW0 + 3'(i), rand_mask_row(mode));
    endtask

    task automatic set_all_taps(logic [11:0] k);
        for (int i = 0; i < KSIZE; i++)
            cfg_write(CFG_MASK_ROW0 + 3'(i), {KSIZE{k}});
    endtask

    // junk above bit 10 must be ignored by the size registers
    task automatic set_dims(int w, int h);
        cfg_write(CFG_IMG_WIDTH, {49'($urandom), 11'(w)});
        cfg_write(CFG_IMG_HEIGHT, {49'($urandom), 11'(h)});
    endtask

    // Valid stays up between back-to-back beats; it only drops for a gap.
    task automatic send_pixel(t_in_item px);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(px);
        sent++;
    endtask

    task automatic send_frames(int n_frames, bit corners);
        int n;
        n = n_frames * sb.eff_w() * sb.eff_h();
        for (int k = 0; k < n; k++)
            send_pixel(corners ? corner_pixel(k) : rand_pixel());
    endtask

    // sender pauses until every expected beat is out, then lets the
    // pipeline and the frame-end sequencer settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus the long hold-off when asked
    initial begin
        int stall;
        stall = 0;
        forever begin
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) stall = pick_gap();
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
                sb.check_result(o_out_data);
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity mask (center tap 1.0): output equals input, 3x3 frame
        set_dims(3, 3);
        set_all_taps(12'h000);
        cfg_write(CFG_MASK_ROW0 + 3'd2, 60'h400 << (COEF_BITS * 2));
        cfg_close();
        send_frames(1, 1'b1);
        drain();

        // most negative taps: everything floors to zero
        set_dims(5, 2);
        set_all_taps(12'h800);
        cfg_close();
        send_frames(1, 1'b1);
        drain();

        // most positive taps: saturation at 255; width 0 counts as 1
        set_dims(0, 4);
        set_all_taps(12'h7FF);
        cfg_close();
        send_frames(1, 1'b1);
        drain();

        // oversize width saturates to the maximum line; start of the line only
        set_dims(2047, 1);
        set_masks(1);
        cfg_close();
        for (int k = 0; k < 60; k++) send_pixel(rand_pixel());
        drain();

        // single column, oversize height; top of the frame only
        set_dims(1, 2047);
        set_masks(1);
        cfg_close();
        for (int k = 0; k < 60; k++) send_pixel(rand_pixel());
        drain();

        // shrink in mid-frame: the next beat restarts at the origin
        set_dims(6, 6);
        set_masks(1);
        cfg_close();
        for (int k = 0; k < 20; k++) send_pixel(rand_pixel());
        drain();
        set_dims(6, 3);
        cfg_close();
        send_frames(2, 1'b0);
        drain();

        // long receiver hold-off while the sender keeps offering beats
        set_dims(10, 10);
        set_masks(1);
        cfg_close();
        quiet = 1'b1;
        hold_left = 400;
        send_frames(1, 1'b0);
        drain();
        quiet = 1'b0;

        // random sizes and masks, a few stretches with no idling
        while (sent < 500) begin
            set_dims($urandom_range(1, 12), $urandom_range(1, 12));
            set_masks(($urandom_range(0, 3) == 0) ? 0 : 1);
            cfg_close();
            quiet = ($urandom_range(0, 4) == 0);
            send_frames($urandom_range(1, 2), 1'b0);
            drain();
            quiet = 1'b0;
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
